/* design/overwriting_log_ring_with_cursor_assert.svh */
// Assertion helpers for the log ring. Both sample on the rising edge of i_clk
// and stay quiet while i_rst_n is low.
`ifndef OVERWRITING_LOG_RING_WITH_CURSOR_ASSERT_SVH
`define OVERWRITING_LOG_RING_WITH_CURSOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OLRC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("log ring check failed");

// Consequent must hold in the cycle after the antecedent.
`define OLRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("log ring check failed");

`endif

/* design/olrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olrc_pkg;

    localparam int CAP_W    = 9;
    localparam int CURSOR_W = 32;
    localparam int WORD_W   = 64;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Memory access issued by the ring controller for one transaction.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [CAP_W-1:0] idx;
    } t_mem_req;

    // Everything of a result except the entry word itself.
    typedef struct packed {
        logic                hit;
        logic [CURSOR_W-1:0] next_cursor;
        logic [CURSOR_W-1:0] evicted;
    } t_meta;

endpackage

`default_nettype wire

/* design/olrc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module olrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/olrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module olrc_ctrl
    import olrc_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_command,
    input  wire logic [CURSOR_W-1:0] i_read_cursor,
    input  wire logic                i_cfg_we,
    input  wire logic [CAP_W-1:0]    i_cfg_data,
    output t_mem_req                 o_mem_req,
    output t_meta                    o_meta
);

    localparam int CAP_MAX = (RING_DEPTH > 256) ? 256 : RING_DEPTH;

    logic [CAP_W-1:0]    r_cap,    n_cap;
    logic [CAP_W-1:0]    r_head,   n_head;
    logic [CAP_W-1:0]    r_start,  n_start;
    logic [CAP_W-1:0]    r_held,   n_held;
    logic [CURSOR_W-1:0] r_total,  n_total;
    logic [CURSOR_W-1:0] r_oldest, n_oldest;

    logic                do_append;
    logic                full;
    logic [CAP_W:0]      head_inc;
    logic [CAP_W-1:0]    head_wrap;
    logic [CURSOR_W-1:0] total_inc;
    logic [CAP_W-1:0]    held_inc;

    logic [CURSOR_W-1:0] c_clamp;
    logic                lagging;
    logic [CURSOR_W-1:0] c_sync;
    logic                hit;
    logic [CURSOR_W-1:0] offset;
    logic [CAP_W:0]      slot_sum;
    logic [CAP_W-1:0]    slot;

    assign do_append = i_accept && (i_command == CMD_APPEND) && (r_cap != '0);
    assign full      = (r_held == r_cap);

    // Append bookkeeping: head wraps at the capacity, the oldest slot follows
    // the head once the ring is full.
    always_comb begin
        head_inc  = {1'b0, r_head} + (CAP_W+1)'(1);
        head_wrap = (head_inc == {1'b0, r_cap}) ? '0 : head_inc[CAP_W-1:0];
        total_inc = r_total + CURSOR_W'(1);
        held_inc  = full ? r_held : r_held + CAP_W'(1);
    end

    always_comb begin
        n_cap    = r_cap;
        n_head   = r_head;
        n_start  = r_start;
        n_held   = r_held;
        n_total  = r_total;
        n_oldest = r_oldest;
        if (i_cfg_we) begin
            n_cap    = (32'(i_cfg_data) > CAP_MAX) ? CAP_W'(CAP_MAX) : i_cfg_data;
            n_head   = '0;
            n_start  = '0;
            n_held   = '0;
            n_total  = '0;
            n_oldest = '0;
        end else if (do_append) begin
            n_head   = head_wrap;
            n_start  = full ? head_wrap : r_start;
            n_held   = held_inc;
            n_total  = total_inc;
            n_oldest = (total_inc >= CURSOR_W'(held_inc))
                     ? total_inc - CURSOR_W'(held_inc) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_W'(CAP_MAX);
            r_head   <= '0;
            r_start  <= '0;
            r_held   <= '0;
            r_total  <= '0;
            r_oldest <= '0;
        end else begin
            r_cap    <= n_cap;
            r_head   <= n_head;
            r_start  <= n_start;
            r_held   <= n_held;
            r_total  <= n_total;
            r_oldest <= n_oldest;
        end
    end

    // Drain: clamp, resync, then locate the slot. The offset from the oldest
    // entry is below the held count, so one conditional subtract wraps it.
    always_comb begin
        c_clamp  = (i_read_cursor > r_total) ? r_total : i_read_cursor;
        lagging  = (c_clamp < r_oldest);
        c_sync   = lagging ? r_oldest : c_clamp;
        hit      = (c_sync < r_total) && (r_held != '0) && (r_cap != '0);
        offset   = c_sync - r_oldest;
        slot_sum = {1'b0, r_start} + {1'b0, offset[CAP_W-1:0]};
        slot     = (slot_sum >= {1'b0, r_cap}) ? CAP_W'(slot_sum - {1'b0, r_cap})
                                               : slot_sum[CAP_W-1:0];
    end

    always_comb begin
        o_mem_req.wr_en = do_append;
        o_mem_req.rd_en = i_accept && (i_command == CMD_DRAIN) && hit;
        o_mem_req.idx   = (i_command == CMD_APPEND) ? r_head : slot;

        o_meta = '0;
        if (i_command == CMD_DRAIN) begin
            if (r_cap == '0) begin
                o_meta.next_cursor = i_read_cursor;
            end else begin
                o_meta.hit         = hit;
                o_meta.next_cursor = hit ? c_sync + CURSOR_W'(1) : c_sync;
                o_meta.evicted     = lagging ? r_oldest - c_clamp : '0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/overwriting_log_ring_with_cursor.sv */
`timescale 1ns / 1ps
`default_nettype none

// Overwriting log ring with a reader cursor. An append transaction stores one
// entry word at the head slot and the oldest entries are overwritten once the
// ring holds ring_capacity of them; a drain transaction takes a reader's
// sequence number, clamps it to the number of entries written, jumps it forward
// to the oldest entry still held (reporting how many were lost), and returns
// that entry with the advanced cursor. Every transaction, appends included,
// yields exactly one result transaction. The block accepts one transaction per
// cycle and delivers its result in the cycle after acceptance; the single RAM
// port carries at most one access per transaction, and the input stalls only
// while a result sits in the output register with the output stalled. Writing
// ring_capacity (values above min(RING_DEPTH, 256) saturate, zero disables
// the ring) empties the ring; no clearing pass runs after reset, since a drain
// only ever reads slots written since the last reset or capacity write.

`include "overwriting_log_ring_with_cursor_assert.svh"

module overwriting_log_ring_with_cursor
    import olrc_pkg::*;
#(
    parameter int RING_DEPTH = 256,
    parameter int ENTRY_BITS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_command,
    input  wire logic [WORD_W-1:0]   i_entry_in,
    input  wire logic [CURSOR_W-1:0] i_read_cursor,

    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_entry_valid,
    output logic      [WORD_W-1:0]   o_entry_out,
    output logic      [CURSOR_W-1:0] o_next_cursor,
    output logic      [CURSOR_W-1:0] o_evicted_count,

    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CAP_W-1:0]    i_cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic                  in_accept;
    logic                  cfg_we;
    t_mem_req              mem_req;
    t_meta                 meta;
    logic [ENTRY_BITS-1:0] rdata;

    logic                  r_out_valid, n_out_valid;
    t_meta                 r_meta;

    // The output register is free when empty or when its result is taken in this
    // very cycle, so a new transaction can enter every cycle unless a waiting result is stalled.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Capacity writes must arrive only while the ring is idle; the block does not
    // enforce this, and the port is always ready.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    olrc_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_command     (i_command),
        .i_read_cursor (i_read_cursor),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_mem_req     (mem_req),
        .o_meta        (meta)
    );

    // The RAM read register doubles as the entry half of the output register:
    // it only loads on an accepted drain, which needs a free output slot.
    olrc_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.wr_en),
        .i_re    (mem_req.rd_en),
        .i_addr  (AW'(mem_req.idx)),
        .i_wdata (i_entry_in[ENTRY_BITS-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_meta <= meta;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_entry_valid   = r_meta.hit;
    assign o_entry_out     = r_meta.hit ? WORD_W'(rdata) : '0;
    assign o_next_cursor   = r_meta.next_cursor;
    assign o_evicted_count = r_meta.evicted;

    // The input only stalls behind a result that is waiting.
    `OLRC_ASSERT_SAME(a_stall_needs_result, o_in_stall, o_out_valid)
    // One RAM port: a transaction never both writes and reads.
    `OLRC_ASSERT_SAME(a_single_access, 1'b1, !(mem_req.wr_en && mem_req.rd_en))
    // A drain that found an entry presents it in the next cycle.
    `OLRC_ASSERT_NEXT(a_drain_hit_shown, mem_req.rd_en, o_out_valid && o_entry_valid)
    // An append reports an all-zero result.
    `OLRC_ASSERT_NEXT(a_append_zero, in_accept && (i_command == CMD_APPEND),
        o_out_valid && !o_entry_valid && (o_next_cursor == '0) && (o_evicted_count == '0))

endmodule

`default_nettype wire
